### design/lscf_pkg.sv
`default_nettype none
package lscf_pkg;

    localparam int COORD_W        = 16;
    localparam int OUT_W          = 24;
    localparam int HELD_W         = 11;
    localparam int DEF_MAX_POINTS = 1024;

    localparam int SX_W = 26;
    localparam int SQ_W = 42;
    localparam int CU_W = 58;

    // datapath word for the normal equations, digits of the shared multiplier
    localparam int W       = 192;
    localparam int DIG_W   = 32;
    localparam int DIGITS  = W / DIG_W;
    localparam int DIG_IW  = $clog2(DIGITS);
    localparam int DIV_CW  = $clog2(W);

    localparam int GUARD_BITS = 8;
    localparam int CLAMP_BITS = 48;
    localparam int CEN_W      = CLAMP_BITS + 2;
    localparam int SQ_TOP     = 62;
    localparam int SQ_W64     = 64;

    localparam int RF_AW    = 5;
    localparam int RF_DEPTH = 2 ** RF_AW;
    localparam int PC_W     = 6;

    typedef enum logic [1:0] {
        FIT_OK    = 2'd0,
        FIT_FEW   = 2'd1,
        FIT_DEGEN = 2'd2,
        FIT_DROP  = 2'd3
    } fit_status_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               start_new_set;
    } point_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic [OUT_W-1:0]        radius;
        fit_status_t             fit_status;
        logic [HELD_W-1:0]       points_held;
    } fit_t;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SHL,
        OP_CNEG,
        OP_SGN,
        OP_CHKNEG,
        OP_DIV,
        OP_DIVCL,
        OP_SQRT
    } op_t;

    typedef logic [RF_AW-1:0] raddr_t;

    localparam raddr_t R_N    = 5'd0;
    localparam raddr_t R_SX   = 5'd1;
    localparam raddr_t R_SY   = 5'd2;
    localparam raddr_t R_SXX  = 5'd3;
    localparam raddr_t R_SYY  = 5'd4;
    localparam raddr_t R_SXY  = 5'd5;
    localparam raddr_t R_SX3  = 5'd6;
    localparam raddr_t R_SY3  = 5'd7;
    localparam raddr_t R_SXYY = 5'd8;
    localparam raddr_t R_SXXY = 5'd9;
    localparam raddr_t R_SR   = 5'd10;
    localparam raddr_t R_T1   = 5'd11;
    localparam raddr_t R_T2   = 5'd12;
    localparam raddr_t R_C    = 5'd13;
    localparam raddr_t R_D    = 5'd14;
    localparam raddr_t R_G    = 5'd15;
    localparam raddr_t R_E    = 5'd16;
    localparam raddr_t R_H    = 5'd17;
    localparam raddr_t R_DET  = 5'd18;
    localparam raddr_t R_NA   = 5'd19;
    localparam raddr_t R_NB   = 5'd20;
    localparam raddr_t R_DEN  = 5'd21;
    localparam raddr_t R_AG   = 5'd22;
    localparam raddr_t R_BG   = 5'd23;
    localparam raddr_t R_S    = 5'd24;

    // shift amounts ride in the src_b field of shift ops
    localparam raddr_t SH_G  = raddr_t'(GUARD_BITS);
    localparam raddr_t SH_GG = raddr_t'(2 * GUARD_BITS);
    localparam raddr_t SH_2G = raddr_t'(GUARD_BITS + 1);
    localparam raddr_t SH_X4 = 5'd2;

    typedef struct packed {
        op_t    op;
        raddr_t dst;
        raddr_t src_a;
        raddr_t src_b;
    } instr_t;

    localparam logic [PC_W-1:0] PC_LAST = 6'd53;

    function automatic instr_t mk(input op_t op, input raddr_t d, input raddr_t a,
                                  input raddr_t b);
        instr_t r;
        r.op    = op;
        r.dst   = d;
        r.src_a = a;
        r.src_b = b;
        return r;
    endfunction

    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            6'd0:    r = mk(OP_ADD,    R_SR,  R_SXX,  R_SYY);
            6'd1:    r = mk(OP_MUL,    R_T1,  R_N,    R_SXX);
            6'd2:    r = mk(OP_MUL,    R_T2,  R_SX,   R_SX);
            6'd3:    r = mk(OP_SUB,    R_C,   R_T1,   R_T2);
            6'd4:    r = mk(OP_MUL,    R_T1,  R_N,    R_SXY);
            6'd5:    r = mk(OP_MUL,    R_T2,  R_SX,   R_SY);
            6'd6:    r = mk(OP_SUB,    R_D,   R_T1,   R_T2);
            6'd7:    r = mk(OP_MUL,    R_T1,  R_N,    R_SYY);
            6'd8:    r = mk(OP_MUL,    R_T2,  R_SY,   R_SY);
            6'd9:    r = mk(OP_SUB,    R_G,   R_T1,   R_T2);
            6'd10:   r = mk(OP_ADD,    R_T1,  R_SX3,  R_SXYY);
            6'd11:   r = mk(OP_MUL,    R_T1,  R_N,    R_T1);
            6'd12:   r = mk(OP_MUL,    R_T2,  R_SR,   R_SX);
            6'd13:   r = mk(OP_SUB,    R_E,   R_T1,   R_T2);
            6'd14:   r = mk(OP_ADD,    R_T1,  R_SXXY, R_SY3);
            6'd15:   r = mk(OP_MUL,    R_T1,  R_N,    R_T1);
            6'd16:   r = mk(OP_MUL,    R_T2,  R_SR,   R_SY);
            6'd17:   r = mk(OP_SUB,    R_H,   R_T1,   R_T2);
            6'd18:   r = mk(OP_MUL,    R_T1,  R_C,    R_G);
            6'd19:   r = mk(OP_MUL,    R_T2,  R_D,    R_D);
            6'd20:   r = mk(OP_SUB,    R_DET, R_T1,   R_T2);
            6'd21:   r = mk(OP_SGN,    R_N,   R_DET,  R_N);
            6'd22:   r = mk(OP_MUL,    R_T1,  R_E,    R_G);
            6'd23:   r = mk(OP_MUL,    R_T2,  R_H,    R_D);
            6'd24:   r = mk(OP_SUB,    R_NA,  R_T1,   R_T2);
            6'd25:   r = mk(OP_MUL,    R_T1,  R_H,    R_C);
            6'd26:   r = mk(OP_MUL,    R_T2,  R_E,    R_D);
            6'd27:   r = mk(OP_SUB,    R_NB,  R_T1,   R_T2);
            6'd28:   r = mk(OP_CNEG,   R_DET, R_DET,  R_N);
            6'd29:   r = mk(OP_CNEG,   R_NA,  R_NA,   R_N);
            6'd30:   r = mk(OP_CNEG,   R_NB,  R_NB,   R_N);
            6'd31:   r = mk(OP_ADD,    R_DEN, R_DET,  R_DET);
            6'd32:   r = mk(OP_SHL,    R_T1,  R_NA,   SH_G);
            6'd33:   r = mk(OP_ADD,    R_T1,  R_T1,   R_DET);
            6'd34:   r = mk(OP_DIVCL,  R_AG,  R_T1,   R_DEN);
            6'd35:   r = mk(OP_SHL,    R_T1,  R_NB,   SH_G);
            6'd36:   r = mk(OP_ADD,    R_T1,  R_T1,   R_DET);
            6'd37:   r = mk(OP_DIVCL,  R_BG,  R_T1,   R_DEN);
            6'd38:   r = mk(OP_SHL,    R_S,   R_SR,   SH_GG);
            6'd39:   r = mk(OP_MUL,    R_T1,  R_AG,   R_SX);
            6'd40:   r = mk(OP_MUL,    R_T2,  R_BG,   R_SY);
            6'd41:   r = mk(OP_ADD,    R_T1,  R_T1,   R_T2);
            6'd42:   r = mk(OP_SHL,    R_T1,  R_T1,   SH_2G);
            6'd43:   r = mk(OP_SUB,    R_S,   R_S,    R_T1);
            6'd44:   r = mk(OP_MUL,    R_T1,  R_AG,   R_AG);
            6'd45:   r = mk(OP_MUL,    R_T2,  R_BG,   R_BG);
            6'd46:   r = mk(OP_ADD,    R_T1,  R_T1,   R_T2);
            6'd47:   r = mk(OP_MUL,    R_T1,  R_N,    R_T1);
            6'd48:   r = mk(OP_ADD,    R_S,   R_S,    R_T1);
            6'd49:   r = mk(OP_CHKNEG, R_N,   R_S,    R_N);
            6'd50:   r = mk(OP_SHL,    R_T1,  R_S,    SH_X4);
            6'd51:   r = mk(OP_SHL,    R_T2,  R_N,    SH_GG);
            6'd52:   r = mk(OP_DIV,    R_T1,  R_T1,   R_T2);
            default: r = mk(OP_SQRT,   R_N,   R_T1,   R_N);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### design/least_squares_circle_fit.sv
`default_nettype none
// Kasa least-squares circle fit over a stream of points. Each accepted point
// updates the count and nine moment sums unless the set already holds
// MAX_POINTS points; once three or more points are held, the block solves the
// 3x3 normal equations exactly in 192-bit integers. It returns center, radius,
// status and the number of points held. The solve uses a single 32x32
// multiplier that builds each wide product from 21 partial products (21
// products per fit), three restoring divisions of 192 steps on the one shared
// divider, and a 32-step square root. The block takes the next point once its
// result sits in the output register.
module least_squares_circle_fit #(
    parameter int MAX_POINTS = lscf_pkg::DEF_MAX_POINTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  lscf_pkg::point_t point,
    output logic             fit_valid,
    input  logic             fit_ready,
    output lscf_pkg::fit_t   fit
);
    import lscf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [W-1:0] CLAMP_LIM = W'(1) << CLAMP_BITS;
    localparam logic signed [CEN_W-1:0] CEN_HI   = CEN_W'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [CEN_W-1:0] CEN_LO   = ~CEN_HI;
    localparam logic signed [CEN_W-1:0] CEN_HALF = CEN_W'(2 ** (GUARD_BITS - 1));
    localparam logic [OUT_W-1:0] RAD_MAX = {OUT_W{1'b1}};
    localparam logic [SQ_W64-1:0] SQ_BIT0 = SQ_W64'(1) << SQ_TOP;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_PROD, S_LOAD, S_RDA, S_RDB, S_OP, S_MUL, S_MULF,
        S_DIV, S_DIVF, S_SQRT, S_SQF, S_WB, S_OUT
    } state_t;

    state_t              state_reg;
    logic [PC_W-1:0]     pc_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic                start_reg;
    logic                dropped_reg;
    fit_status_t         fs_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SX_W-1:0]     sum_x_reg;
    logic [SX_W-1:0]     sum_y_reg;
    logic [SQ_W-1:0]     sum_x_sq_reg;
    logic [SQ_W-1:0]     sum_y_sq_reg;
    logic [CU_W-1:0]     sum_x_cube_reg;
    logic [CU_W-1:0]     sum_y_cube_reg;
    logic [SQ_W-1:0]     sum_x_y_reg;
    logic [CU_W-1:0]     sum_x_y_sq_reg;
    logic [CU_W-1:0]     sum_x_sq_y_reg;
    logic [2:0]          pstep_reg;
    logic [2*COORD_W-1:0] xx_reg;
    logic [2*COORD_W-1:0] yy_reg;
    logic [RF_AW-1:0]    ld_cnt_reg;
    logic [W-1:0]        a_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        res_reg;
    logic [W-1:0]        acc_reg;
    logic [W-1:0]        rem_reg;
    logic                sgn_reg;
    logic                det_neg_reg;
    logic [DIG_IW-1:0]   i_reg;
    logic [DIG_IW-1:0]   j_reg;
    logic [DIG_IW-1:0]   pos_reg;
    logic                pv_reg;
    logic [2*DIG_W-1:0]  prod_reg;
    logic [DIV_CW-1:0]   bit_reg;
    logic [SQ_W64-1:0]   sq_v_reg;
    logic [SQ_W64-1:0]   sq_res_reg;
    logic [SQ_W64-1:0]   sq_bit_reg;
    logic [OUT_W-1:0]    cx_reg;
    logic [OUT_W-1:0]    cy_reg;
    logic [OUT_W-1:0]    rad_reg;
    logic                fit_valid_reg;
    fit_t                fit_reg;

    logic [W-1:0]        rf [RF_DEPTH];
    logic [W-1:0]        rd_data_reg;
    logic [RF_AW-1:0]    rd_addr;
    logic                rf_we;
    logic [RF_AW-1:0]    rf_wa;
    logic [W-1:0]        rf_wd;

    instr_t              cur;
    logic [DIG_W-1:0]    mul_a;
    logic [DIG_W-1:0]    mul_b;
    logic [W-1:0]        acc_add;
    logic [W-1:0]        rem_shift;
    logic [W-1:0]        q_mag;
    logic [SQ_W64-1:0]   sq_try;
    logic [SQ_W64-1:0]   sq_round;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    function automatic logic [OUT_W-1:0] center_out(input logic [W-1:0] g);
        logic signed [CEN_W-1:0] t;
        t = $signed(g[CEN_W-1:0]) + CEN_HALF;
        t = t >>> GUARD_BITS;
        if (t > CEN_HI) begin
            t = CEN_HI;
        end
        if (t < CEN_LO) begin
            t = CEN_LO;
        end
        return t[OUT_W-1:0];
    endfunction

    assign cur         = prog(pc_reg);
    assign point_ready = (state_reg == S_IDLE);
    assign fit_valid   = fit_valid_reg;
    assign fit         = fit_reg;

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PROD:
            begin
                case (pstep_reg)
                    3'd0:
                    begin
                        mul_a = DIG_W'(x_reg);
                        mul_b = DIG_W'(x_reg);
                    end
                    3'd1:
                    begin
                        mul_a = DIG_W'(y_reg);
                        mul_b = DIG_W'(y_reg);
                    end
                    3'd2:
                    begin
                        mul_a = DIG_W'(x_reg);
                        mul_b = DIG_W'(y_reg);
                    end
                    3'd3:
                    begin
                        mul_a = xx_reg;
                        mul_b = DIG_W'(x_reg);
                    end
                    3'd4:
                    begin
                        mul_a = yy_reg;
                        mul_b = DIG_W'(y_reg);
                    end
                    3'd5:
                    begin
                        mul_a = yy_reg;
                        mul_b = DIG_W'(x_reg);
                    end
                    3'd6:
                    begin
                        mul_a = xx_reg;
                        mul_b = DIG_W'(y_reg);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_MUL:
            begin
                mul_a = a_reg[int'(i_reg) * DIG_W +: DIG_W];
                mul_b = b_reg[int'(j_reg) * DIG_W +: DIG_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign acc_add   = acc_reg + (W'(prod_reg) << (DIG_W * int'(pos_reg)));
    assign rem_shift = {rem_reg[W-2:0], a_reg[W-1]};
    assign q_mag     = (acc_reg > CLAMP_LIM) ? CLAMP_LIM : acc_reg;
    assign sq_try    = sq_res_reg + sq_bit_reg;
    assign sq_round  = (sq_res_reg + SQ_W64'(1)) >> 1;

    // register file port control
    always_comb
    begin
        case (state_reg)
            S_RDB:   rd_addr = cur.src_b;
            default: rd_addr = cur.src_a;
        endcase
        rf_we = (state_reg == S_LOAD) || (state_reg == S_WB);
        rf_wa = (state_reg == S_LOAD) ? ld_cnt_reg : cur.dst;
        rf_wd = res_reg;
        if (state_reg == S_LOAD) begin
            case (ld_cnt_reg)
                R_N:     rf_wd = W'(count_reg);
                R_SX:    rf_wd = W'(sum_x_reg);
                R_SY:    rf_wd = W'(sum_y_reg);
                R_SXX:   rf_wd = W'(sum_x_sq_reg);
                R_SYY:   rf_wd = W'(sum_y_sq_reg);
                R_SXY:   rf_wd = W'(sum_x_y_reg);
                R_SX3:   rf_wd = W'(sum_x_cube_reg);
                R_SY3:   rf_wd = W'(sum_y_cube_reg);
                R_SXYY:  rf_wd = W'(sum_x_y_sq_reg);
                R_SXXY:  rf_wd = W'(sum_x_sq_y_reg);
                default: rf_wd = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we) begin
            rf[rf_wa] <= rf_wd;
        end
        rd_data_reg <= rf[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            start_reg      <= 1'b0;
            dropped_reg    <= 1'b0;
            fs_reg         <= FIT_OK;
            count_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_x_sq_reg   <= '0;
            sum_y_sq_reg   <= '0;
            sum_x_cube_reg <= '0;
            sum_y_cube_reg <= '0;
            sum_x_y_reg    <= '0;
            sum_x_y_sq_reg <= '0;
            sum_x_sq_y_reg <= '0;
            pstep_reg      <= '0;
            xx_reg         <= '0;
            yy_reg         <= '0;
            ld_cnt_reg     <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            res_reg        <= '0;
            acc_reg        <= '0;
            rem_reg        <= '0;
            sgn_reg        <= 1'b0;
            det_neg_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pos_reg        <= '0;
            pv_reg         <= 1'b0;
            prod_reg       <= '0;
            bit_reg        <= '0;
            sq_v_reg       <= '0;
            sq_res_reg     <= '0;
            sq_bit_reg     <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            rad_reg        <= '0;
            fit_valid_reg  <= 1'b0;
            fit_reg        <= '0;
        end else begin
            prod_reg <= mul_a * mul_b;
            if (fit_valid_reg && fit_ready && (state_reg != S_OUT)) begin
                fit_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (point_valid) begin
                        x_reg     <= point.point_x;
                        y_reg     <= point.point_y;
                        start_reg <= point.start_new_set;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    cx_reg    <= '0;
                    cy_reg    <= '0;
                    rad_reg   <= '0;
                    fs_reg    <= FIT_OK;
                    pstep_reg <= '0;
                    ld_cnt_reg <= '0;
                    if (start_reg) begin
                        count_reg      <= '0;
                        sum_x_reg      <= '0;
                        sum_y_reg      <= '0;
                        sum_x_sq_reg   <= '0;
                        sum_y_sq_reg   <= '0;
                        sum_x_cube_reg <= '0;
                        sum_y_cube_reg <= '0;
                        sum_x_y_reg    <= '0;
                        sum_x_y_sq_reg <= '0;
                        sum_x_sq_y_reg <= '0;
                        dropped_reg    <= 1'b0;
                        state_reg      <= S_PROD;
                    end else if (count_reg < CNT_W'(MAX_POINTS)) begin
                        dropped_reg <= 1'b0;
                        state_reg   <= S_PROD;
                    end else begin
                        dropped_reg <= 1'b1;
                        state_reg   <= S_LOAD;
                    end
                end
                // point products, one per cycle, each summed in the cycle after
                S_PROD:
                begin
                    pstep_reg <= pstep_reg + 3'd1;
                    case (pstep_reg)
                        3'd0:
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            sum_x_reg <= sum_x_reg + SX_W'(x_reg);
                            sum_y_reg <= sum_y_reg + SX_W'(y_reg);
                        end
                        3'd1:
                        begin
                            xx_reg       <= prod_reg[2*COORD_W-1:0];
                            sum_x_sq_reg <= sum_x_sq_reg + SQ_W'(prod_reg);
                        end
                        3'd2:
                        begin
                            yy_reg       <= prod_reg[2*COORD_W-1:0];
                            sum_y_sq_reg <= sum_y_sq_reg + SQ_W'(prod_reg);
                        end
                        3'd3: sum_x_y_reg    <= sum_x_y_reg + SQ_W'(prod_reg);
                        3'd4: sum_x_cube_reg <= sum_x_cube_reg + CU_W'(prod_reg);
                        3'd5: sum_y_cube_reg <= sum_y_cube_reg + CU_W'(prod_reg);
                        3'd6: sum_x_y_sq_reg <= sum_x_y_sq_reg + CU_W'(prod_reg);
                        default:
                        begin
                            sum_x_sq_y_reg <= sum_x_sq_y_reg + CU_W'(prod_reg);
                            state_reg      <= S_LOAD;
                        end
                    endcase
                end
                S_LOAD:
                begin
                    if (count_reg < CNT_W'(3)) begin
                        fs_reg    <= FIT_FEW;
                        state_reg <= S_OUT;
                    end else if (ld_cnt_reg == R_SXXY) begin
                        pc_reg    <= '0;
                        state_reg <= S_RDA;
                    end else begin
                        ld_cnt_reg <= ld_cnt_reg + RF_AW'(1);
                    end
                end
                S_RDA:
                begin
                    state_reg <= S_RDB;
                end
                S_RDB:
                begin
                    a_reg     <= rd_data_reg;
                    state_reg <= S_OP;
                end
                S_OP:
                begin
                    case (cur.op)
                        OP_ADD:
                        begin
                            res_reg   <= a_reg + rd_data_reg;
                            state_reg <= S_WB;
                        end
                        OP_SUB:
                        begin
                            res_reg   <= a_reg - rd_data_reg;
                            state_reg <= S_WB;
                        end
                        OP_SHL:
                        begin
                            res_reg   <= a_reg << cur.src_b;
                            state_reg <= S_WB;
                        end
                        OP_CNEG:
                        begin
                            res_reg   <= det_neg_reg ? -a_reg : a_reg;
                            state_reg <= S_WB;
                        end
                        OP_SGN:
                        begin
                            if (a_reg == '0) begin
                                fs_reg    <= FIT_DEGEN;
                                state_reg <= S_OUT;
                            end else begin
                                det_neg_reg <= a_reg[W-1];
                                pc_reg      <= pc_reg + PC_W'(1);
                                state_reg   <= S_RDA;
                            end
                        end
                        OP_CHKNEG:
                        begin
                            if (a_reg[W-1]) begin
                                fs_reg    <= FIT_DEGEN;
                                cx_reg    <= '0;
                                cy_reg    <= '0;
                                state_reg <= S_OUT;
                            end else begin
                                pc_reg    <= pc_reg + PC_W'(1);
                                state_reg <= S_RDA;
                            end
                        end
                        OP_MUL:
                        begin
                            sgn_reg   <= a_reg[W-1] ^ rd_data_reg[W-1];
                            a_reg     <= mag(a_reg);
                            b_reg     <= mag(rd_data_reg);
                            acc_reg   <= '0;
                            i_reg     <= '0;
                            j_reg     <= '0;
                            pv_reg    <= 1'b0;
                            state_reg <= S_MUL;
                        end
                        OP_DIV, OP_DIVCL:
                        begin
                            // floor division: a negative numerator becomes den - 1 - num
                            sgn_reg   <= a_reg[W-1];
                            a_reg     <= a_reg[W-1] ? (rd_data_reg + ~a_reg) : a_reg;
                            b_reg     <= rd_data_reg;
                            acc_reg   <= '0;
                            rem_reg   <= '0;
                            bit_reg   <= DIV_CW'(W - 1);
                            state_reg <= S_DIV;
                        end
                        OP_SQRT:
                        begin
                            if (|a_reg[W-1:SQ_TOP]) begin
                                rad_reg   <= RAD_MAX;
                                state_reg <= S_OUT;
                            end else begin
                                sq_v_reg   <= a_reg[SQ_W64-1:0];
                                sq_res_reg <= '0;
                                sq_bit_reg <= SQ_BIT0;
                                state_reg  <= S_SQRT;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_MUL:
                begin
                    pv_reg  <= 1'b1;
                    pos_reg <= i_reg + j_reg;
                    if (pv_reg) begin
                        acc_reg <= acc_add;
                    end
                    if (int'(i_reg) + int'(j_reg) == DIGITS - 1) begin
                        if (int'(i_reg) == DIGITS - 1) begin
                            state_reg <= S_MULF;
                        end else begin
                            i_reg <= i_reg + DIG_IW'(1);
                            j_reg <= '0;
                        end
                    end else begin
                        j_reg <= j_reg + DIG_IW'(1);
                    end
                end
                S_MULF:
                begin
                    res_reg   <= sgn_reg ? -acc_add : acc_add;
                    state_reg <= S_WB;
                end
                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    a_reg <= a_reg << 1;
                    if (rem_shift >= b_reg) begin
                        rem_reg <= rem_shift - b_reg;
                        acc_reg <= {acc_reg[W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_shift;
                        acc_reg <= {acc_reg[W-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - DIV_CW'(1);
                    if (bit_reg == '0) begin
                        state_reg <= S_DIVF;
                    end
                end
                S_DIVF:
                begin
                    if (cur.op == OP_DIVCL) begin
                        res_reg <= sgn_reg ? -q_mag : q_mag;
                    end else begin
                        res_reg <= sgn_reg ? -acc_reg : acc_reg;
                    end
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (cur.dst == R_AG) begin
                        cx_reg <= center_out(res_reg);
                    end
                    if (cur.dst == R_BG) begin
                        cy_reg <= center_out(res_reg);
                    end
                    pc_reg    <= pc_reg + PC_W'(1);
                    state_reg <= (pc_reg == PC_LAST) ? S_OUT : S_RDA;
                end
                S_SQRT:
                begin
                    if (sq_v_reg >= sq_try) begin
                        sq_v_reg   <= sq_v_reg - sq_try;
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        state_reg <= S_SQF;
                    end
                end
                S_SQF:
                begin
                    rad_reg   <= (sq_round > SQ_W64'(RAD_MAX)) ? RAD_MAX
                                                              : sq_round[OUT_W-1:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!fit_valid_reg || fit_ready) begin
                        fit_reg.center_x    <= (fs_reg == FIT_OK) ? cx_reg : '0;
                        fit_reg.center_y    <= (fs_reg == FIT_OK) ? cy_reg : '0;
                        fit_reg.radius      <= (fs_reg == FIT_OK) ? rad_reg : '0;
                        fit_reg.fit_status  <= dropped_reg ? FIT_DROP : fs_reg;
                        fit_reg.points_held <= HELD_W'(count_reg);
                        fit_valid_reg       <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### tb/sv/least_squares_circle_fit_checker.sv
module least_squares_circle_fit_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    input  logic             point_ready,
    input  lscf_pkg::point_t point,
    input  logic             fit_valid,
    input  logic             fit_ready,
    input  lscf_pkg::fit_t   fit,
    output int               errors,
    output int               pending
);
    import lscf_pkg::*;

    typedef logic signed [255:0] big_t;
    typedef logic [255:0] ubig_t;

    localparam longint CENTER_LIM = longint'(1) << 48;

    int              held;
    logic [SX_W-1:0] acc_x, acc_y;
    logic [SQ_W-1:0] acc_xx, acc_yy, acc_xy;
    logic [CU_W-1:0] acc_xxx, acc_yyy, acc_xyy, acc_xxy;
    fit_t            expected_fits[$];

    function automatic big_t floor_div(big_t a, big_t b);
        ubig_t ua;
        if (a >= 0)
            return big_t'(ubig_t'(a) / ubig_t'(b));
        ua = ubig_t'(-a) + ubig_t'(b) - 1;
        return -big_t'(ua / ubig_t'(b));
    endfunction

    function automatic longint clamp_center(big_t a);
        ubig_t  m;
        longint v;
        m = (a < 0) ? ubig_t'(-a) : ubig_t'(a);
        if (m > ubig_t'(CENTER_LIM))
            v = CENTER_LIM;
        else
            v = longint'(m[63:0]);
        return (a < 0) ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v)
            bit_w = bit_w >> 2;
        while (bit_w != 0)
        begin
            if (v >= res + bit_w)
            begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end
            else
                res = res >> 1;
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic [OUT_W-1:0] round_center(longint g);
        longint t, c;
        t = g + 128;
        c = t >>> GUARD_BITS;
        if (c > 8388607)
            c = 8388607;
        if (c < -8388608)
            c = -8388608;
        return c[OUT_W-1:0];
    endfunction

    function automatic fit_t solve_circle();
        fit_t        r;
        big_t        n, sx, sy, sxx, syy, sxy, sr, c, d, g, e, h, det, na, nb, den;
        big_t        s, q4;
        longint      ag, bg;
        logic [63:0] t;
        r = '0;
        r.fit_status = FIT_FEW;
        r.points_held = held[HELD_W-1:0];
        if (held < 3)
            return r;
        n = big_t'(held);
        sx = big_t'(acc_x);
        sy = big_t'(acc_y);
        sxx = big_t'(acc_xx);
        syy = big_t'(acc_yy);
        sxy = big_t'(acc_xy);
        sr = sxx + syy;
        c = n * sxx - sx * sx;
        d = n * sxy - sx * sy;
        g = n * syy - sy * sy;
        e = n * (big_t'(acc_xxx) + big_t'(acc_xyy)) - sr * sx;
        h = n * (big_t'(acc_xxy) + big_t'(acc_yyy)) - sr * sy;
        det = c * g - d * d;
        r.fit_status = FIT_DEGEN;
        if (det == 0)
            return r;
        na = e * g - h * d;
        nb = h * c - e * d;
        if (det < 0)
        begin
            det = -det;
            na = -na;
            nb = -nb;
        end
        den = det + det;
        ag = clamp_center(floor_div(na * 256 + det, den));
        bg = clamp_center(floor_div(nb * 256 + det, den));
        s = sr * 65536 - (big_t'(ag) * sx + big_t'(bg) * sy) * 512
            + n * (big_t'(ag) * big_t'(ag) + big_t'(bg) * big_t'(bg));
        if (s < 0)
            return r;
        q4 = floor_div(s * 4, n * 65536);
        if (ubig_t'(q4) >= (ubig_t'(1) << 62))
            t = 64'hFF_FFFF;
        else
        begin
            t = (int_sqrt(q4[63:0]) + 1) >> 1;
            if (t > 64'hFF_FFFF)
                t = 64'hFF_FFFF;
        end
        r.center_x = round_center(ag);
        r.center_y = round_center(bg);
        r.radius = t[OUT_W-1:0];
        r.fit_status = FIT_OK;
        return r;
    endfunction

    function automatic fit_t add_point(point_t p);
        logic [63:0] x, y;
        logic        dropped;
        fit_t        r;
        x = 64'(p.point_x);
        y = 64'(p.point_y);
        dropped = 1'b0;
        if (p.start_new_set)
        begin
            held = 0;
            {acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
            {acc_xxx, acc_yyy, acc_xyy, acc_xxy} = '0;
        end
        if (held < DEF_MAX_POINTS)
        begin
            held++;
            acc_x += x[SX_W-1:0];
            acc_y += y[SX_W-1:0];
            acc_xx += SQ_W'(x * x);
            acc_yy += SQ_W'(y * y);
            acc_xy += SQ_W'(x * y);
            acc_xxx += CU_W'(x * x * x);
            acc_yyy += CU_W'(y * y * y);
            acc_xyy += CU_W'(x * y * y);
            acc_xxy += CU_W'(x * x * y);
        end
        else
            dropped = 1'b1;
        r = solve_circle();
        if (dropped)
            r.fit_status = FIT_DROP;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fit_t want;
        if (!rst_n)
        begin
            held = 0;
            {acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
            {acc_xxx, acc_yyy, acc_xyy, acc_xxy} = '0;
            expected_fits.delete();
            errors = 0;
        end
        else
        begin
            if (fit_valid && fit_ready)
            begin
                if (expected_fits.size() == 0)
                begin
                    $display("%0t: unexpected fit %p", $time, fit);
                    errors++;
                end
                else
                begin
                    want = expected_fits.pop_front();
                    if (want.center_x !== fit.center_x)
                    begin
                        $display("%0t: center_x exp %0d act %0d", $time,
                                 want.center_x, fit.center_x);
                        errors++;
                    end
                    if (want.center_y !== fit.center_y)
                    begin
                        $display("%0t: center_y exp %0d act %0d", $time,
                                 want.center_y, fit.center_y);
                        errors++;
                    end
                    if (want.radius !== fit.radius)
                    begin
                        $display("%0t: radius exp %0d act %0d", $time,
                                 want.radius, fit.radius);
                        errors++;
                    end
                    if (want.fit_status !== fit.fit_status)
                    begin
                        $display("%0t: fit_status exp %0d act %0d", $time,
                                 want.fit_status, fit.fit_status);
                        errors++;
                    end
                    if (want.points_held !== fit.points_held)
                    begin
                        $display("%0t: points_held exp %0d act %0d", $time,
                                 want.points_held, fit.points_held);
                        errors++;
                    end
                end
            end
            if (point_valid && point_ready)
                expected_fits.insert(expected_fits.size(), add_point(point));
        end
        pending = expected_fits.size();
    end

endmodule

### tb/sv/least_squares_circle_fit_tb.sv
module least_squares_circle_fit_tb;
    import lscf_pkg::*;

    logic   clk;
    logic   rst_n;
    logic   point_valid;
    logic   point_ready;
    point_t point;
    logic   fit_valid;
    logic   fit_ready = 1'b0;
    fit_t   fit;
    int     errors;
    int     pending;

    int     send_idle_pct;
    int     recv_stall_pct;
    logic   hold_req;
    logic   hold_done = 1'b0;
    int     idle_cycles = 0;
    int     n_sent;
    int     n_sets;

    least_squares_circle_fit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .fit_valid   (fit_valid),
        .fit_ready   (fit_ready),
        .fit         (fit)
    );

    least_squares_circle_fit_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .fit_valid   (fit_valid),
        .fit_ready   (fit_ready),
        .fit         (fit),
        .errors      (errors),
        .pending     (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver side with one long hold-off on request
    always @(posedge clk)
    begin
        int k;
        if (hold_req && !hold_done)
        begin
            fit_ready <= 1'b0;
            for (k = 0; k < 4000; k++)
                @(posedge clk);
            hold_done = 1'b1;
        end
        fit_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((point_valid && point_ready) || (fit_valid && fit_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("timeout, %0d fits outstanding", pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic st);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            point_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_valid <= 1'b1;
        point.point_x <= x;
        point.point_y <= y;
        point.start_new_set <= st;
        do
            @(negedge clk);
        while (!point_ready);
        @(posedge clk);
        n_sent++;
        if (n_sent == 450)
        begin
            send_idle_pct = 65;
            recv_stall_pct = 15;
        end
        if (n_sent == 800)
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
    endtask

    task automatic send_circle_set(input int len);
        int  i, cx, cy, r, px, py;
        real a;
        cx = $urandom_range(6000, 59000);
        cy = $urandom_range(6000, 59000);
        r = $urandom_range(40, 6000);
        for (i = 0; i < len; i++)
        begin
            a = $urandom_range(0, 6283) / 1000.0;
            px = cx + int'(r * $cos(a)) + $urandom_range(0, 8) - 4;
            py = cy + int'(r * $sin(a)) + $urandom_range(0, 8) - 4;
            send_point(px[15:0], py[15:0], i == 0);
        end
        n_sets++;
    endtask

    initial
    begin
        int i, len;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        hold_req = 1'b0;
        n_sent = 0;
        n_sets = 0;
        send_idle_pct = 15;
        recv_stall_pct = 65;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // too few points, then extremes
        send_point(16'd0, 16'd0, 1'b1);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'd0, 16'hFFFF, 1'b0);
        send_point(16'hFFFF, 16'd0, 1'b0);
        // collinear
        send_point(16'd0, 16'd0, 1'b1);
        send_point(16'd16, 16'd16, 1'b0);
        send_point(16'd32, 16'd32, 1'b0);
        // coincident
        send_point(16'd100, 16'd100, 1'b1);
        send_point(16'd100, 16'd100, 1'b0);
        send_point(16'd100, 16'd100, 1'b0);
        // clean circle
        send_point(16'd1600, 16'd800, 1'b1);
        send_point(16'd800, 16'd1600, 1'b0);
        send_point(16'd0, 16'd800, 1'b0);
        send_point(16'd800, 16'd0, 1'b0);
        // far corners
        send_point(16'hFFFF, 16'hFFFF, 1'b1);
        send_point(16'hFFFF, 16'd0, 1'b0);
        send_point(16'd0, 16'hFFFF, 1'b0);
        send_point(16'd0, 16'd0, 1'b0);

        while (n_sent < 200)
        begin
            len = $urandom_range(1, 25);
            if ($urandom_range(9) < 8)
                send_circle_set(len);
            else
                for (i = 0; i < len; i++)
                    send_point(16'($urandom), 16'($urandom), ($urandom_range(9) == 0));
            if (n_sent >= 100)
                hold_req = 1'b1;
        end

        // drain completely before going on
        point_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);

        // fill the set to capacity, drop a few, restart at capacity
        for (i = 0; i < DEF_MAX_POINTS + 4; i++)
            send_point(16'($urandom), 16'($urandom), i == 0);
        send_point(16'($urandom), 16'($urandom), 1'b1);
        send_point(16'($urandom), 16'($urandom), 1'b0);

        while (n_sent < 1350)
        begin
            len = $urandom_range(1, 25);
            if ($urandom_range(9) < 8)
                send_circle_set(len);
            else
                for (i = 0; i < len; i++)
                    send_point(16'($urandom), 16'($urandom), ($urandom_range(9) == 0));
        end
        point_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d points in %0d circle sets plus noise, extremes,", n_sent, n_sets);
        $display("degenerate sets and a full set with dropped points");
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
